FILE: rtl/stf_pkg.sv
// Package for the surface traction forcing block: widths, payload structs,
// cell state types and saturating arithmetic helpers. No dependencies.
package stf_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int JAC_W = 31;
  localparam int VAL_W = 32;
  localparam int STR_W = FRACTION_BITS + 1;
  localparam int REC_W = 2 * FRACTION_BITS + 1;
  localparam int SQ_W = (JAC_W + FRACTION_BITS + 1) / 2;
  localparam int NSTEP = (REC_W > SQ_W) ? REC_W : SQ_W;
  localparam int SQ_PAD = NSTEP - SQ_W;
  localparam int RXY_W = 3 * FRACTION_BITS + 1;
  localparam int P_W = 64 - FRACTION_BITS;
  localparam int P_LW = P_W / 2;
  localparam int P_HW = P_W - P_LW;
  localparam int A_LW = RXY_W / 2;
  localparam int A_HW = RXY_W - A_LW;
  localparam int WIDE_W = 128;
  localparam int MST = 7;
  localparam int NSTG = NSTEP + MST;

  typedef struct packed {
    logic [JAC_W-1:0] jacobian;
    logic signed [VAL_W-1:0] metric_x;
    logic signed [VAL_W-1:0] metric_y;
    logic signed [VAL_W-1:0] metric_z;
    logic signed [VAL_W-1:0] stress_xx;
    logic signed [VAL_W-1:0] stress_xy;
    logic signed [VAL_W-1:0] stress_xz;
    logic signed [VAL_W-1:0] stress_yy;
    logic signed [VAL_W-1:0] stress_yz;
    logic signed [VAL_W-1:0] stress_zz;
    logic [STR_W-1:0] stretch_x;
    logic [STR_W-1:0] stretch_y;
  } stf_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] force_x;
    logic signed [VAL_W-1:0] force_y;
    logic signed [VAL_W-1:0] force_z;
  } stf_out_t;

  typedef struct packed {
    logic [NSTEP-1:0] quo;
    logic [STR_W:0] rem;
    logic [NSTEP-1:0] dvd;
    logic [STR_W-1:0] dsr;
  } stf_div_t;

  typedef struct packed {
    logic [NSTEP-1:0] root;
    logic [NSTEP+1:0] rem;
    logic [2*NSTEP-1:0] rad;
  } stf_sqrt_t;

  typedef struct packed {
    stf_in_t data;
    stf_sqrt_t sq;
    stf_div_t dx;
    stf_div_t dy;
  } stf_cell_t;

  function automatic logic signed [63:0] floor_sat64(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x >>> FRACTION_BITS;
    if (y[WIDE_W-1:63] == '0 || y[WIDE_W-1:63] == '1) begin
      return y[63:0];
    end
    return y[WIDE_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic signed [31:0] floor_sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x >>> FRACTION_BITS;
    if (y[WIDE_W-1:31] == '0 || y[WIDE_W-1:31] == '1) begin
      return y[31:0];
    end
    return y[WIDE_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

FILE: rtl/stf_cell.sv
// One cell of the iteration row: one square root digit and one quotient bit
// for each reciprocal, carrying the request along. Depends on stf_pkg.
module stf_cell (
  input  logic              clk,
  input  logic              load,
  input  stf_pkg::stf_cell_t prev,
  output stf_pkg::stf_cell_t cur
);
  import stf_pkg::*;

  stf_cell_t cur_next;

  function automatic stf_div_t div_step(input stf_div_t d);
    stf_div_t o;
    logic [STR_W:0] r;
    o = d;
    r = {d.rem[STR_W-1:0], d.dvd[NSTEP-1]};
    o.dvd = {d.dvd[NSTEP-2:0], 1'b0};
    if (r >= {1'b0, d.dsr}) begin
      o.rem = r - {1'b0, d.dsr};
      o.quo = {d.quo[NSTEP-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {d.quo[NSTEP-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic stf_sqrt_t sqrt_step(input stf_sqrt_t s);
    stf_sqrt_t o;
    logic [NSTEP+3:0] rs;
    logic [NSTEP+3:0] tr;
    o = s;
    rs = {s.rem, s.rad[2*NSTEP-1:2*NSTEP-2]};
    tr = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[2*NSTEP-3:0], 2'b00};
    if (rs >= tr) begin
      o.rem = NSTEP'(0) + (NSTEP+2)'(rs - tr);
      o.root = {s.root[NSTEP-2:0], 1'b1};
    end else begin
      o.rem = rs[NSTEP+1:0];
      o.root = {s.root[NSTEP-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    cur_next.data = prev.data;
    cur_next.sq = sqrt_step(prev.sq);
    cur_next.dx = div_step(prev.dx);
    cur_next.dy = div_step(prev.dy);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= cur_next;
    end
  end

endmodule

FILE: rtl/stf_lane.sv
// One forcing component: metric products, scaled terms, saturating sum and
// the final square root scaling, in seven register stages. Depends on stf_pkg.
module stf_lane (
  input  logic                               clk,
  input  logic [stf_pkg::MST-1:0]            ld,
  input  logic signed [stf_pkg::VAL_W-1:0]   m_x,
  input  logic signed [stf_pkg::VAL_W-1:0]   m_y,
  input  logic signed [stf_pkg::VAL_W-1:0]   m_z,
  input  logic signed [stf_pkg::VAL_W-1:0]   t_a,
  input  logic signed [stf_pkg::VAL_W-1:0]   t_b,
  input  logic signed [stf_pkg::VAL_W-1:0]   t_c,
  input  logic [stf_pkg::REC_W-1:0]          rx,
  input  logic [stf_pkg::REC_W-1:0]          ry,
  input  logic [stf_pkg::RXY_W-1:0]          rxy,
  input  logic [stf_pkg::SQ_W-1:0]           sj,
  output logic signed [stf_pkg::VAL_W-1:0]   force_out
);
  import stf_pkg::*;

  logic signed [63:0] pa_full, pb_full, pc_full;
  logic signed [P_W-1:0] pa, pb, pc;
  logic signed [REC_W+P_HW:0] q1h, q2h;
  logic [REC_W+P_LW-1:0] q1l, q2l;
  logic [A_LW+P_LW-1:0] c_ll;
  logic signed [A_LW+P_HW:0] c_lh;
  logic [A_HW+P_LW-1:0] c_hl;
  logic signed [A_HW+P_HW:0] c_hh;
  logic signed [63:0] term1, term2, term3, term3_d, sum12, sum;
  logic [SQ_W+31:0] e_l;
  logic signed [SQ_W+32:0] e_h;

  assign pa_full = m_x * t_a;
  assign pb_full = m_y * t_b;
  assign pc_full = m_z * t_c;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      pa <= P_W'(pa_full >>> FRACTION_BITS);
      pb <= P_W'(pb_full >>> FRACTION_BITS);
      pc <= P_W'(pc_full >>> FRACTION_BITS);
    end
    if (ld[1]) begin
      q1h <= $signed({1'b0, ry}) * $signed(pa[P_W-1:P_LW]);
      q1l <= ry * pa[P_LW-1:0];
      q2h <= $signed({1'b0, rx}) * $signed(pb[P_W-1:P_LW]);
      q2l <= rx * pb[P_LW-1:0];
      c_ll <= rxy[A_LW-1:0] * pc[P_LW-1:0];
      c_lh <= $signed({1'b0, rxy[A_LW-1:0]}) * $signed(pc[P_W-1:P_LW]);
      c_hl <= rxy[RXY_W-1:A_LW] * pc[P_LW-1:0];
      c_hh <= $signed({1'b0, rxy[RXY_W-1:A_LW]}) * $signed(pc[P_W-1:P_LW]);
    end
    if (ld[2]) begin
      term1 <= floor_sat64((WIDE_W'(q1h) <<< P_LW) + WIDE_W'($signed({1'b0, q1l})));
      term2 <= floor_sat64((WIDE_W'(q2h) <<< P_LW) + WIDE_W'($signed({1'b0, q2l})));
      term3 <= floor_sat64((WIDE_W'(c_hh) <<< (A_LW + P_LW)) + (WIDE_W'(c_lh) <<< P_LW)
                           + (WIDE_W'($signed({1'b0, c_hl})) <<< A_LW)
                           + WIDE_W'($signed({1'b0, c_ll})));
    end
    if (ld[3]) begin
      sum12 <= add_sat64(term1, term2);
      term3_d <= term3;
    end
    if (ld[4]) begin
      sum <= add_sat64(sum12, term3_d);
    end
    if (ld[5]) begin
      e_l <= sj * sum[31:0];
      e_h <= $signed({1'b0, sj}) * $signed(sum[63:32]);
    end
    if (ld[6]) begin
      force_out <= floor_sat32((WIDE_W'(e_h) <<< 32) + WIDE_W'($signed({1'b0, e_l})));
    end
  end

endmodule

FILE: rtl/surface_traction_forcing.sv
// Top level of the surface traction forcing block: input conditioning, the
// row of iteration cells, shared reciprocal product and three lanes.
// Depends on stf_pkg, stf_cell and stf_lane.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data  (stf_in_t)
// out       output     out_valid / out_ready out_data (stf_out_t)
//
// One request per cycle is accepted while in_ready is high. Each result passes
// the row of 33 cells, one quotient bit and one root digit each, followed by
// the seven register stages of the three lanes.
// Reset clears only the stage valid bits. A stalled output holds only the unbroken
// run of full stages behind it; earlier and empty stages keep accepting requests.
module surface_traction_forcing (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  stf_pkg::stf_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output stf_pkg::stf_out_t out_data
);
  import stf_pkg::*;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] ld;
  stf_cell_t chain [NSTEP+1];
  stf_in_t last;
  logic [REC_W-1:0] rx, ry;
  logic [RXY_W-1:0] rxy;
  logic [2*REC_W-1:0] rr_prod;
  logic [SQ_W-1:0] sj [MST-2];

  always_comb begin
    ld[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign in_ready = ld[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (ld[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_comb begin
    chain[0].data = in_data;
    chain[0].sq.root = '0;
    chain[0].sq.rem = '0;
    chain[0].sq.rad = (2*NSTEP)'({in_data.jacobian, {FRACTION_BITS{1'b0}}}) << (2*SQ_PAD);
    chain[0].dx.quo = '0;
    chain[0].dx.rem = '0;
    chain[0].dx.dvd = NSTEP'(1) << (2*FRACTION_BITS);
    chain[0].dx.dsr = (in_data.stretch_x == '0) ? STR_W'(1) : in_data.stretch_x;
    chain[0].dy.quo = '0;
    chain[0].dy.rem = '0;
    chain[0].dy.dvd = NSTEP'(1) << (2*FRACTION_BITS);
    chain[0].dy.dsr = (in_data.stretch_y == '0) ? STR_W'(1) : in_data.stretch_y;
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    stf_cell u_cell (
      .clk  (clk),
      .load (ld[g]),
      .prev (chain[g]),
      .cur  (chain[g+1])
    );
  end

  assign last = chain[NSTEP].data;
  assign rr_prod = chain[NSTEP].dx.quo[REC_W-1:0] * chain[NSTEP].dy.quo[REC_W-1:0];

  always_ff @(posedge clk) begin
    if (ld[NSTEP]) begin
      rx <= chain[NSTEP].dx.quo[REC_W-1:0];
      ry <= chain[NSTEP].dy.quo[REC_W-1:0];
      rxy <= rr_prod[FRACTION_BITS+RXY_W-1:FRACTION_BITS];
      sj[0] <= chain[NSTEP].sq.root[SQ_PAD+SQ_W-1:SQ_PAD];
    end
    for (int k = 1; k < MST - 2; k++) begin
      if (ld[NSTEP+k]) begin
        sj[k] <= sj[k-1];
      end
    end
  end

  stf_lane u_lane_x (
    .clk (clk), .ld (ld[NSTG-1:NSTEP]),
    .m_x (last.metric_x), .m_y (last.metric_y), .m_z (last.metric_z),
    .t_a (last.stress_xx), .t_b (last.stress_xy), .t_c (last.stress_xz),
    .rx (rx), .ry (ry), .rxy (rxy), .sj (sj[MST-3]),
    .force_out (out_data.force_x)
  );

  stf_lane u_lane_y (
    .clk (clk), .ld (ld[NSTG-1:NSTEP]),
    .m_x (last.metric_x), .m_y (last.metric_y), .m_z (last.metric_z),
    .t_a (last.stress_xy), .t_b (last.stress_yy), .t_c (last.stress_yz),
    .rx (rx), .ry (ry), .rxy (rxy), .sj (sj[MST-3]),
    .force_out (out_data.force_y)
  );

  stf_lane u_lane_z (
    .clk (clk), .ld (ld[NSTG-1:NSTEP]),
    .m_x (last.metric_x), .m_y (last.metric_y), .m_z (last.metric_z),
    .t_a (last.stress_xz), .t_b (last.stress_yz), .t_c (last.stress_zz),
    .rx (rx), .ry (ry), .rxy (rxy), .sj (sj[MST-3]),
    .force_out (out_data.force_z)
  );

endmodule

FILE: tb/tb.sv
// Regression bench for surface_traction_forcing: a directed table and random
// grid points, predicted in exact fixed point and checked per component.
// Depends on stf_pkg and the surface_traction_forcing RTL.
`timescale 1ns / 100ps

module tb;
  import stf_pkg::*;

  typedef logic signed [63:0] q64_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    stf_in_t  pt;
    bit       known;
    stf_out_t want;
  } row_t;

  localparam int RANDOM_POINTS = 1000;
  localparam q64_t Q_MAX = {1'b0, {63{1'b1}}};
  localparam q64_t Q_MIN = {1'b1, 63'd0};
  localparam logic signed [31:0] F_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] F_MIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  stf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  stf_out_t out_data;

  stf_out_t forces_due[$];
  int errors = 0;
  bit steady = 1'b0;
  bit inputs_done = 1'b0;
  row_t table_rows[$];

  surface_traction_forcing uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic q64_t qmul(q64_t a, q64_t b);
    wide_t p;
    wide_t y;
    p = wide_t'(a) * wide_t'(b);
    y = p >>> FRACTION_BITS;
    if (y > wide_t'(Q_MAX)) begin
      return Q_MAX;
    end
    if (y < wide_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return y[63:0];
  endfunction

  function automatic q64_t qadd(q64_t a, q64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Q_MAX)) begin
      return Q_MAX;
    end
    if (s < 65'(Q_MIN)) begin
      return Q_MIN;
    end
    return s[63:0];
  endfunction

  function automatic q64_t reciprocal(logic [STR_W-1:0] s);
    logic [63:0] d;
    d = (s == 0) ? 64'd1 : 64'(s);
    return q64_t'((64'd1 << (2 * FRACTION_BITS)) / d);
  endfunction

  function automatic q64_t root_of(logic [JAC_W-1:0] j);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = 64'(j) << FRACTION_BITS;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= v) begin
        r = b;
      end
    end
    return q64_t'(r);
  endfunction

  function automatic logic signed [31:0] traction(q64_t sj, q64_t rx, q64_t ry, q64_t rxy,
      stf_in_t p, logic signed [31:0] ta, logic signed [31:0] tb,
      logic signed [31:0] tc);
    q64_t sum;
    q64_t r;
    sum = qmul(ry, qmul(q64_t'(p.metric_x), q64_t'(ta)));
    sum = qadd(sum, qmul(rx, qmul(q64_t'(p.metric_y), q64_t'(tb))));
    sum = qadd(sum, qmul(rxy, qmul(q64_t'(p.metric_z), q64_t'(tc))));
    r = qmul(sj, sum);
    if (r > 64'(F_MAX)) begin
      return F_MAX;
    end
    if (r < 64'(F_MIN)) begin
      return F_MIN;
    end
    return r[31:0];
  endfunction

  function automatic stf_out_t surface_forces(stf_in_t p);
    stf_out_t f;
    q64_t rx;
    q64_t ry;
    q64_t rxy;
    q64_t sj;
    rx = reciprocal(p.stretch_x);
    ry = reciprocal(p.stretch_y);
    rxy = qmul(rx, ry);
    sj = root_of(p.jacobian);
    f.force_x = traction(sj, rx, ry, rxy, p, p.stress_xx, p.stress_xy, p.stress_xz);
    f.force_y = traction(sj, rx, ry, rxy, p, p.stress_xy, p.stress_yy, p.stress_yz);
    f.force_z = traction(sj, rx, ry, rxy, p, p.stress_xz, p.stress_yz, p.stress_zz);
    return f;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return F_MAX;
      1: return F_MIN;
      2: return 32'sd0;
      3: return 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
      4: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STR_W-1:0] pick_stretch();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'd1;
      2: return 17'h10000;
      3: return 17'h1ffff;
      default: return 17'($urandom_range(1, 17'h1ffff));
    endcase
  endfunction

  function automatic stf_in_t random_point();
    stf_in_t p;
    p.jacobian = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
    p.metric_x = pick32();
    p.metric_y = pick32();
    p.metric_z = pick32();
    p.stress_xx = pick32();
    p.stress_xy = pick32();
    p.stress_xz = pick32();
    p.stress_yy = pick32();
    p.stress_yz = pick32();
    p.stress_zz = pick32();
    p.stretch_x = pick_stretch();
    p.stretch_y = pick_stretch();
    return p;
  endfunction

  function automatic row_t make_row(logic [JAC_W-1:0] j, logic signed [31:0] m,
      logic signed [31:0] t, logic [STR_W-1:0] s, bit known, stf_out_t want);
    row_t r;
    r.pt = '{j, m, m, m, t, t, t, t, t, t, s, s};
    r.known = known;
    r.want = want;
    return r;
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < 30);
  endfunction

  task automatic send(stf_in_t p);
    in_data <= p;
    in_valid <= 1'b1;
    forces_due.push_back(surface_forces(p));
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    row_t r;
    table_rows.push_back(make_row(31'd0, F_MAX, F_MAX, 17'h10000, 1'b1, '0));
    table_rows.push_back(make_row(31'h7fffffff, F_MAX, F_MAX, 17'd0, 1'b1,
                                  {F_MAX, F_MAX, F_MAX}));
    table_rows.push_back(make_row(31'h7fffffff, F_MIN, F_MAX, 17'd0, 1'b1,
                                  {F_MIN, F_MIN, F_MIN}));
    table_rows.push_back(make_row(31'h7fffffff, F_MIN, F_MIN, 17'h1ffff, 1'b0, '0));
    table_rows.push_back(make_row(31'h10000, 32'sh10000, 32'sh10000, 17'h10000, 1'b1,
                                  {32'sh30000, 32'sh30000, 32'sh30000}));
    table_rows.push_back(make_row(31'h10000, 32'sh10000, -32'sh10000, 17'h10000, 1'b1,
                                  {-32'sh30000, -32'sh30000, -32'sh30000}));
    table_rows.push_back(make_row(31'h10000, 32'sh10000, 32'sd0, 17'h1, 1'b1, '0));
    table_rows.push_back(make_row(31'h40000, -32'sh1, 32'sh1, 17'h8000, 1'b0, '0));
    table_rows.push_back(make_row(31'h1, 32'sh1, -32'sh1, 17'h1ffff, 1'b0, '0));
    table_rows.push_back(make_row(31'h2aaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 17'h15555,
                                  1'b0, '0));
    table_rows.push_back(make_row(31'h55555555, 32'shaaaaaaaa, 32'sh55555555, 17'h0aaaa,
                                  1'b0, '0));
    r.pt = '{31'h10000, 32'sh10000, 32'sh20000, -32'sh10000, 32'sh1000, -32'sh2000,
             32'sh3000, 32'sh4000, -32'sh5000, 32'sh6000, 17'h10000, 17'h8000};
    r.known = 1'b0;
    table_rows.push_back(r);
    r.pt = '{31'h7fffffff, 32'sh100, -32'sh300, 32'sh7, F_MIN, F_MAX, 32'sd0, 32'sh1,
             -32'sh1, 32'sh12345, 17'h0, 17'h1ffff};
    table_rows.push_back(r);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) begin
      while (idle_now()) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      if (table_rows[i].known && surface_forces(table_rows[i].pt) != table_rows[i].want) begin
        $display("directed row %0d: table entry disagrees with prediction", i);
        errors++;
      end
      send(table_rows[i].pt);
    end
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      steady = (n >= 300 && n < 450);
      while (idle_now()) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      send(random_point());
    end
    steady = 1'b0;
    in_valid <= 1'b0;
    while (forces_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    inputs_done = 1'b1;
  end

  always @(posedge clk) begin
    stf_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (forces_due.size() == 0) begin
          $display("unexpected request at output at %0t", $time);
          errors++;
        end else begin
          want = forces_due.pop_front();
          if (out_data.force_x !== want.force_x) report("force_x", out_data.force_x, want.force_x);
          if (out_data.force_y !== want.force_y) report("force_y", out_data.force_y, want.force_y);
          if (out_data.force_z !== want.force_z) report("force_z", out_data.force_z, want.force_z);
        end
      end
      out_ready <= !idle_now();
    end
  end

  initial begin
    wait (inputs_done);
    if (errors == 0) begin
      $display("surface_traction_forcing regression: pass");
    end else begin
      $display("surface_traction_forcing regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("surface_traction_forcing regression: fail");
    $finish;
  end

endmodule

FILE: surface_traction_forcing.f
rtl/stf_pkg.sv
rtl/stf_cell.sv
rtl/stf_lane.sv
rtl/surface_traction_forcing.sv
tb/tb.sv
